@@ src/bqs_pkg.sv @@
`timescale 1ns / 1ps

package bqs_pkg;

  localparam int COORD_W = 32;
  localparam int ID_W    = 32;
  localparam int COND_W  = 31;
  localparam int ENTRY_W = 64;
  localparam int IDX_W   = 2;

  // Local gradient factors are 4x the shape-function gradient, Q28.
  localparam int LG_W = 30;
  localparam logic signed [LG_W-1:0] ONE_Q28   = 30'sd268435456;
  localparam logic signed [LG_W-1:0] GAUSS_Q28 = 30'sd154981283;

  // Corner n of the element: xi is negative at nodes 0 and 3, eta at 0 and 1.
  function automatic logic xi_neg(logic [1:0] n);
    return (n == 2'd0) || (n == 2'd3);
  endfunction

  function automatic logic eta_neg(logic [1:0] n);
    return !n[1];
  endfunction

  // Gradient factor of node n along local direction dir (0: xi, 1: eta)
  // at Gauss point g, whose signs follow the corner with the same number.
  function automatic logic signed [LG_W-1:0] lgrad(logic [1:0] g, logic [1:0] n,
                                                  logic dir);
    logic outer_neg;
    logic plus;
    logic signed [LG_W-1:0] mag;
    if (!dir) begin
      outer_neg = xi_neg(n);
      plus      = (eta_neg(g) == eta_neg(n));
    end else begin
      outer_neg = eta_neg(n);
      plus      = (xi_neg(g) == xi_neg(n));
    end
    mag = plus ? (ONE_Q28 + GAUSS_Q28) : (ONE_Q28 - GAUSS_Q28);
    return outer_neg ? -mag : mag;
  endfunction

endpackage

@@ src/bqs_node_if.sv @@
`timescale 1ns / 1ps

interface bqs_node_if;
  logic                            valid;
  logic                            ready;
  logic signed [bqs_pkg::COORD_W-1:0] node_x;
  logic signed [bqs_pkg::COORD_W-1:0] node_y;
  logic [bqs_pkg::ID_W-1:0]        node_id;
  logic [bqs_pkg::COND_W-1:0]      cond_x;
  logic [bqs_pkg::COND_W-1:0]      cond_y;
  logic                            last_node;

  modport source (output valid, node_x, node_y, node_id, cond_x, cond_y, last_node,
                  input ready);
  modport sink (input valid, node_x, node_y, node_id, cond_x, cond_y, last_node,
                output ready);
endinterface

@@ src/bqs_entry_if.sv @@
`timescale 1ns / 1ps

interface bqs_entry_if;
  logic                              valid;
  logic                              ready;
  logic [bqs_pkg::IDX_W-1:0]         row;
  logic [bqs_pkg::IDX_W-1:0]         col;
  logic signed [bqs_pkg::ENTRY_W-1:0] entry_value;
  logic                              kept;
  logic                              degenerate;
  logic                              last_entry;

  modport source (output valid, row, col, entry_value, kept, degenerate, last_entry,
                  input ready);
  modport sink (input valid, row, col, entry_value, kept, degenerate, last_entry,
                output ready);
endinterface

@@ src/bilinear_quad_element_stiffness_core.sv @@
`timescale 1ns / 1ps

// Q4 element stiffness, 2x2 Gauss quadrature, diagonal conductivity.
// in_ch takes node transactions (x, y, id, conductivities) while idle; the
// transaction with last_node set, or the one that fills the fourth slot,
// closes the element and in_ch drops ready until all 16 entries leave.
// out_ch then gives entries (row, col) in row-major order, one at a time, from
// one output register that holds its value while the receiver stalls.
// Compute per element: accumulator clear and keep mask, then per Gauss point
// Jacobian, normalize, det, gradients and a term for every kept entry through
// the one-bit-a-cycle 64-step divider (skipped when the quotient saturates).
// All products share a single 33x33 multiplier. Node slots and Q values sit in
// small RAMs; the 16 entries sit in one RAM read and written back per term.
// A zero Jacobian or determinant sends all entries out as zero.
// Reset (rst_n low, synchronous) returns to idle with the slot count at zero.
module bilinear_quad_element_stiffness_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bqs_node_if.sink    in_ch,
  bqs_entry_if.source out_ch
);

  localparam int SH = 36 - FRAC_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_JAC  = 4'd2;
  localparam logic [3:0] S_NORM = 4'd3;
  localparam logic [3:0] S_DET  = 4'd4;
  localparam logic [3:0] S_QC   = 4'd5;
  localparam logic [3:0] S_TRM  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_RND  = 4'd8;
  localparam logic [3:0] S_SGN  = 4'd9;
  localparam logic [3:0] S_ACC  = 4'd10;
  localparam logic [3:0] S_ORD  = 4'd11;
  localparam logic [3:0] S_OLD  = 4'd12;
  localparam logic [3:0] S_OWT  = 4'd13;

  localparam logic signed [63:0] JACC_INIT = 64'sd134217728;
  localparam logic signed [63:0] QACC_INIT = 64'sd2147483648;
  localparam logic signed [63:0] I64_MAX   = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] I64_MIN   = {1'b1, {63{1'b0}}};

  logic [3:0] state_r;
  logic [1:0] node_cnt_r;
  logic [5:0] cnt_r;
  logic [1:0] g_r;
  logic [3:0] e_r;
  logic [15:0] keep_r;
  logic degen_r;
  logic [bqs_pkg::COND_W-1:0] kx_r, ky_r;

  logic signed [63:0] jacc_r [4];
  logic signed [35:0] j_r [4];
  logic [35:0] ow_r;
  logic signed [63:0] det_r;
  logic signed [63:0] qacc_r;
  logic signed [63:0] sx_r, sy_r;
  logic signed [127:0] num_r;
  logic neg_r, sat_r;
  logic [63:0] dabs_r, rem_r, quo_r;
  logic signed [63:0] term_r;

  // memories
  logic [63:0] crd_mem [4];
  logic [bqs_pkg::ID_W-1:0] id_mem [4];
  logic signed [31:0] q_mem [8];
  logic signed [63:0] acc_mem [16];

  logic [63:0] crd_rd_r;
  logic [bqs_pkg::ID_W-1:0] id_rd_a_r, id_rd_b_r;
  logic signed [31:0] q_rd_a_r, q_rd_b_r;
  logic signed [63:0] acc_rd_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;

  logic in_acc;
  logic [5:0] cnt_m1, cnt_m2;
  logic [1:0] crd_ra, id_ra, id_rb;
  logic [2:0] q_ra, q_rb, q_wa;
  logic q_we;
  logic signed [63:0] qsum_nxt;
  logic acc_we;
  logic [3:0] acc_wa;
  logic signed [63:0] acc_wd;
  logic signed [64:0] sum_nxt;
  logic signed [63:0] sat_nxt;
  logic [35:0] ow_nxt;
  logic [64:0] rem2;
  logic rem_ge;
  logic signed [127:0] nabs;
  logic [63:0] mag;
  logic id_le;
  logic [3:0] keep_idx;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && rst_n;
  assign cnt_m1  = cnt_r - 6'd1;
  assign cnt_m2  = cnt_r - 6'd2;
  assign keep_idx = cnt_m1[3:0];
  assign id_le   = (id_rd_a_r <= id_rd_b_r);

  assign crd_ra = cnt_r[3:2];
  assign id_ra  = cnt_r[3:2];
  assign id_rb  = cnt_r[1:0];
  assign q_ra   = {cnt_r[0], e_r[3:2]};
  assign q_rb   = {cnt_r[0], e_r[1:0]};
  assign q_wa   = {cnt_m1[1], cnt_m1[3:2]};
  assign q_we   = (state_r == S_QC) && (cnt_r != 6'd0) && cnt_m1[0];
  assign qsum_nxt = qacc_r - prod_r[63:0];

  assign acc_we = ((state_r == S_CLR) && !cnt_r[4]) || (state_r == S_ACC);
  assign acc_wa = (state_r == S_CLR) ? cnt_r[3:0] : e_r;
  assign sum_nxt = {acc_rd_r[63], acc_rd_r} + {term_r[63], term_r};
  assign sat_nxt = (sum_nxt[64] != sum_nxt[63]) ? (sum_nxt[64] ? I64_MIN : I64_MAX)
                                                : sum_nxt[63:0];
  assign acc_wd = (state_r == S_CLR) ? 64'sd0 : sat_nxt;

  assign rem2   = {rem_r, num_r[63]};
  assign rem_ge = (rem2 >= {1'b0, dabs_r});
  assign nabs   = num_r[127] ? -num_r : num_r;
  assign mag    = quo_r[63] ? I64_MAX : quo_r;

  always_comb begin
    ow_nxt = '0;
    for (int x = 0; x < 4; x++) begin
      ow_nxt = ow_nxt | (j_r[x][35] ? 36'(-j_r[x]) : 36'(j_r[x]));
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_JAC: begin
        mul_a = 33'(bqs_pkg::lgrad(g_r, cnt_m1[3:2], cnt_m1[0]));
        mul_b = cnt_m1[1] ? 33'(signed'(crd_rd_r[31:0])) : 33'(signed'(crd_rd_r[63:32]));
      end
      S_DET: begin
        mul_a = (cnt_r == 6'd0) ? 33'(signed'(j_r[0][30:0])) : 33'(signed'(j_r[2][30:0]));
        mul_b = (cnt_r == 6'd0) ? 33'(signed'(j_r[3][30:0])) : 33'(signed'(j_r[1][30:0]));
      end
      S_QC: begin
        mul_a = 33'(bqs_pkg::lgrad(g_r, cnt_r[3:2], cnt_r[0] ^ cnt_r[1]));
        case (cnt_r[1:0])
          2'd0:    mul_b = 33'(signed'(j_r[3][30:0]));
          2'd1:    mul_b = 33'(signed'(j_r[2][30:0]));
          2'd2:    mul_b = 33'(signed'(j_r[0][30:0]));
          default: mul_b = 33'(signed'(j_r[1][30:0]));
        endcase
      end
      S_TRM: begin
        case (cnt_r)
          6'd1, 6'd2: begin
            mul_a = 33'(q_rd_a_r);
            mul_b = 33'(q_rd_b_r);
          end
          6'd3: begin
            mul_a = $signed({2'b00, kx_r});
            mul_b = $signed({1'b0, sx_r[31:0]});
          end
          6'd4: begin
            mul_a = $signed({2'b00, kx_r});
            mul_b = $signed({sx_r[63], sx_r[63:32]});
          end
          6'd5: begin
            mul_a = $signed({2'b00, ky_r});
            mul_b = $signed({1'b0, sy_r[31:0]});
          end
          6'd6: begin
            mul_a = $signed({2'b00, ky_r});
            mul_b = $signed({sy_r[63], sy_r[63:32]});
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // node slot RAMs
  always_ff @(posedge clk) begin
    if (in_acc) begin
      crd_mem[node_cnt_r] <= {in_ch.node_x, in_ch.node_y};
    end
    crd_rd_r <= crd_mem[crd_ra];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_mem[node_cnt_r] <= in_ch.node_id;
    end
    id_rd_a_r <= id_mem[id_ra];
    id_rd_b_r <= id_mem[id_rb];
  end

  // global gradient RAM: Q0 at 0..3, Q1 at 4..7
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= qsum_nxt[63:32];
    end
    q_rd_a_r <= q_mem[q_ra];
    q_rd_b_r <= q_mem[q_rb];
  end

  // entry accumulators; read address is always the current entry
  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_rd_r <= acc_mem[e_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      node_cnt_r <= 2'd0;
      cnt_r      <= 6'd0;
      g_r        <= 2'd0;
      e_r        <= 4'd0;
      degen_r    <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.last_node || (node_cnt_r == 2'd3)) begin
              node_cnt_r <= 2'd0;
              kx_r       <= in_ch.cond_x;
              ky_r       <= in_ch.cond_y;
              degen_r    <= 1'b0;
              cnt_r      <= 6'd0;
              e_r        <= 4'd0;
              state_r    <= S_CLR;
            end else begin
              node_cnt_r <= node_cnt_r + 2'd1;
            end
          end
        end
        S_CLR: begin
          // clear entries and build the keep mask from id pairs, one per cycle
          if (cnt_r != 6'd0) begin
            keep_r[keep_idx] <= id_le;
          end
          if (cnt_r == 6'd16) begin
            g_r     <= 2'd0;
            cnt_r   <= 6'd0;
            state_r <= S_JAC;
            for (int x = 0; x < 4; x++) jacc_r[x] <= JACC_INIT;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_JAC: begin
          // read slot, multiply, accumulate: three-deep pipe over 16 products
          if (cnt_r >= 6'd2) begin
            jacc_r[cnt_m2[1:0]] <= jacc_r[cnt_m2[1:0]] + prod_r[63:0];
          end
          if (cnt_r == 6'd17) begin
            cnt_r   <= 6'd0;
            state_r <= S_NORM;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_NORM: begin
          if (cnt_r == 6'd0) begin
            for (int x = 0; x < 4; x++) j_r[x] <= jacc_r[x][63:28];
            cnt_r <= 6'd1;
          end else if (cnt_r == 6'd1) begin
            ow_r  <= ow_nxt;
            cnt_r <= 6'd2;
          end else if (ow_r == 36'd0) begin
            degen_r <= 1'b1;
            e_r     <= 4'd0;
            state_r <= S_ORD;
          end else if (ow_r[35:30] != 6'd0) begin
            // bit length of the OR equals that of the largest magnitude
            ow_r <= ow_r >> 1;
            for (int x = 0; x < 4; x++) j_r[x] <= j_r[x] >>> 1;
          end else if (!ow_r[29]) begin
            ow_r <= ow_r << 1;
            for (int x = 0; x < 4; x++) j_r[x] <= j_r[x] <<< 1;
          end else begin
            cnt_r   <= 6'd0;
            state_r <= S_DET;
          end
        end
        S_DET: begin
          case (cnt_r)
            6'd0: cnt_r <= 6'd1;
            6'd1: begin
              det_r <= prod_r[63:0];
              cnt_r <= 6'd2;
            end
            6'd2: begin
              det_r <= det_r - prod_r[63:0];
              cnt_r <= 6'd3;
            end
            default: begin
              cnt_r <= 6'd0;
              if (det_r == 64'sd0) begin
                degen_r <= 1'b1;
                e_r     <= 4'd0;
                state_r <= S_ORD;
              end else begin
                state_r <= S_QC;
              end
            end
          endcase
        end
        S_QC: begin
          if ((cnt_r != 6'd0) && !cnt_m1[0]) begin
            qacc_r <= QACC_INIT + prod_r[63:0];
          end
          if (cnt_r == 6'd16) begin
            cnt_r   <= 6'd0;
            e_r     <= 4'd0;
            state_r <= S_TRM;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_TRM: begin
          cnt_r <= cnt_r + 6'd1;
          case (cnt_r)
            6'd0: begin
              if (!keep_r[e_r]) begin
                cnt_r <= 6'd0;
                if (e_r == 4'd15) begin
                  e_r <= 4'd0;
                  if (g_r == 2'd3) begin
                    state_r <= S_ORD;
                  end else begin
                    g_r     <= g_r + 2'd1;
                    state_r <= S_JAC;
                    for (int x = 0; x < 4; x++) jacc_r[x] <= JACC_INIT;
                  end
                end else begin
                  e_r <= e_r + 4'd1;
                end
              end
            end
            6'd2: sx_r <= prod_r[63:0];
            6'd3: sy_r <= prod_r[63:0];
            6'd4: num_r <= 128'(prod_r);
            6'd5: num_r <= num_r + {{30{prod_r[65]}}, prod_r, 32'd0};
            6'd6: num_r <= num_r + 128'(prod_r);
            6'd7: num_r <= num_r + {{30{prod_r[65]}}, prod_r, 32'd0};
            6'd8: begin
              neg_r  <= num_r[127] ^ det_r[63];
              num_r  <= nabs <<< SH;
              dabs_r <= det_r[63] ? 64'(-det_r) : 64'(det_r);
            end
            6'd9: begin
              cnt_r <= 6'd0;
              quo_r <= 64'd0;
              if (num_r[127:64] >= dabs_r) begin
                sat_r   <= 1'b1;
                state_r <= S_RND;
              end else begin
                sat_r   <= 1'b0;
                rem_r   <= num_r[127:64];
                state_r <= S_DIV;
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          rem_r <= rem_ge ? 64'(rem2 - {1'b0, dabs_r}) : rem2[63:0];
          quo_r <= {quo_r[62:0], rem_ge};
          num_r <= num_r <<< 1;
          if (cnt_r == 6'd63) begin
            state_r <= S_RND;
          end
          cnt_r <= cnt_r + 6'd1;
        end
        S_RND: begin
          // round half away from zero on the magnitude
          if (sat_r) begin
            quo_r <= {64{1'b1}};
          end else if ((rem_r >= dabs_r - rem_r) && (quo_r != {64{1'b1}})) begin
            quo_r <= quo_r + 64'd1;
          end
          state_r <= S_SGN;
        end
        S_SGN: begin
          term_r  <= neg_r ? -$signed(mag) : $signed(mag);
          state_r <= S_ACC;
        end
        S_ACC: begin
          cnt_r <= 6'd0;
          if (e_r == 4'd15) begin
            e_r <= 4'd0;
            if (g_r == 2'd3) begin
              state_r <= S_ORD;
            end else begin
              g_r     <= g_r + 2'd1;
              state_r <= S_JAC;
              for (int x = 0; x < 4; x++) jacc_r[x] <= JACC_INIT;
            end
          end else begin
            e_r     <= e_r + 4'd1;
            state_r <= S_TRM;
          end
        end
        S_ORD: state_r <= S_OLD;
        S_OLD: begin
          out_ch.entry_value <= degen_r ? 64'sd0 : acc_rd_r;
          state_r <= S_OWT;
        end
        S_OWT: begin
          if (out_ch.ready) begin
            if (e_r == 4'd15) begin
              e_r     <= 4'd0;
              state_r <= S_IDLE;
            end else begin
              e_r     <= e_r + 4'd1;
              state_r <= S_ORD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = (state_r == S_OWT);
  assign out_ch.row        = e_r[3:2];
  assign out_ch.col        = e_r[1:0];
  assign out_ch.kept       = keep_r[e_r];
  assign out_ch.degenerate = degen_r;
  assign out_ch.last_entry = (e_r == 4'd15);

endmodule
